FILE: hdl/sfcc_pkg.sv
`default_nettype none

package sfcc_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [3:0]  FRAME_LAST  = 4'd8;
    localparam logic [1:0]  NO_ERROR    = 2'd3;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    localparam logic [1:0] WORD_CO2  = 2'd0;
    localparam logic [1:0] WORD_TEMP = 2'd1;
    localparam logic [1:0] WORD_HUM  = 2'd2;

    // Role of a byte inside its three-byte word.
    typedef enum logic [1:0] {
        SLOT_HIGH = 2'd0,
        SLOT_LOW  = 2'd1,
        SLOT_CRC  = 2'd2
    } slot_t;

    typedef struct packed {
        logic [1:0] word;
        slot_t      slot;
    } pos_info_t;

    typedef struct packed {
        logic [15:0] co2;
        logic [15:0] temp;
        logic [15:0] hum;
        logic [1:0]  err;
    } frame_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic pos_info_t decode_pos(input logic [3:0] pos);
        pos_info_t info;
        case (pos)
            4'd0:    info = '{word: WORD_CO2,  slot: SLOT_HIGH};
            4'd1:    info = '{word: WORD_CO2,  slot: SLOT_LOW};
            4'd2:    info = '{word: WORD_CO2,  slot: SLOT_CRC};
            4'd3:    info = '{word: WORD_TEMP, slot: SLOT_HIGH};
            4'd4:    info = '{word: WORD_TEMP, slot: SLOT_LOW};
            4'd5:    info = '{word: WORD_TEMP, slot: SLOT_CRC};
            4'd6:    info = '{word: WORD_HUM,  slot: SLOT_HIGH};
            4'd7:    info = '{word: WORD_HUM,  slot: SLOT_LOW};
            default: info = '{word: WORD_HUM,  slot: SLOT_CRC};
        endcase
        return info;
    endfunction

    // floor(x / 65535) for x below 2^31. The high half underestimates the
    // quotient by at most one, and the remainder stays below twice 65535.
    function automatic logic [14:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        if (r >= {1'b0, FULL_SCALE})
            return q0 + 15'd1;
        return q0;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sfcc_if.sv
`default_nettype none

interface sfcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        co2_ppm;
    logic [15:0]        temperature_code;
    logic [15:0]        humidity_code;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               crc_ok;
    logic [1:0]         bad_word;

    modport source (output valid, output co2_ppm, output temperature_code,
                    output humidity_code, output temperature_centi,
                    output humidity_centi, output crc_ok, output bad_word,
                    input ready);
    modport sink   (input valid, input co2_ppm, input temperature_code,
                    input humidity_code, input temperature_centi,
                    input humidity_centi, input crc_ok, input bad_word,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/sfcc_assembler.sv
`default_nettype none

module sfcc_assembler
    import sfcc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfcc_byte_if.sink   byte_ch,
    output frame_t      frame,
    output logic        frame_valid,
    input  wire logic   frame_ready
);

    logic [3:0]  pos_reg,   pos_next;
    logic [7:0]  crc_reg,   crc_next;
    logic [7:0]  high_reg,  high_next;
    logic [15:0] co2_reg,   co2_next;
    logic [15:0] temp_reg,  temp_next;
    logic [15:0] hum_reg,   hum_next;
    logic [1:0]  err_reg,   err_next;
    frame_t      frame_reg, frame_next;
    logic        frame_valid_reg, frame_valid_next;

    logic        acc;
    logic        restart;
    logic [3:0]  pos_eff;
    logic [7:0]  crc_base;
    logic [7:0]  crc_new;
    logic [1:0]  err_base;
    logic [1:0]  err_word;
    pos_info_t   info;
    logic        last;

    // A finished frame waits in its own register, so bytes keep flowing
    // while the converter is stalled, unless a second frame completes.
    assign byte_ch.ready = !frame_valid_reg || frame_ready;
    assign acc           = byte_ch.valid && byte_ch.ready;

    assign restart  = byte_ch.frame_start || (pos_reg > FRAME_LAST);
    assign pos_eff  = restart ? 4'd0 : pos_reg;
    assign crc_base = restart ? CRC_INIT : crc_reg;
    assign err_base = restart ? NO_ERROR : err_reg;
    assign crc_new  = crc8_update(crc_base, byte_ch.rx_byte);
    assign info     = decode_pos(pos_eff);
    assign last     = (pos_eff == FRAME_LAST);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        co2_next   = co2_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        err_next   = err_reg;
        frame_next = frame_reg;
        err_word   = err_base;
        frame_valid_next = frame_valid_reg && !frame_ready;

        if (acc)
        begin
            crc_next = crc_new;
            err_next = err_base;
            case (info.slot)
                SLOT_HIGH:
                begin
                    high_next = byte_ch.rx_byte;
                end
                SLOT_LOW:
                begin
                    case (info.word)
                        WORD_CO2:  co2_next  = {high_reg, byte_ch.rx_byte};
                        WORD_TEMP: temp_next = {high_reg, byte_ch.rx_byte};
                        default:   hum_next  = {high_reg, byte_ch.rx_byte};
                    endcase
                end
                default:
                begin
                    if (crc_new != 8'h00 && err_base == NO_ERROR)
                        err_word = info.word;
                    err_next = err_word;
                    crc_next = CRC_INIT;
                end
            endcase

            if (last)
            begin
                frame_next.co2   = co2_reg;
                frame_next.temp  = temp_reg;
                frame_next.hum   = hum_reg;
                frame_next.err   = err_word;
                frame_valid_next = 1'b1;
                pos_next         = 4'd0;
                crc_next         = CRC_INIT;
                err_next         = NO_ERROR;
            end
            else
            begin
                pos_next = pos_eff + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 4'd0;
            crc_reg         <= CRC_INIT;
            high_reg        <= 8'h00;
            co2_reg         <= 16'h0000;
            temp_reg        <= 16'h0000;
            hum_reg         <= 16'h0000;
            err_reg         <= NO_ERROR;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            high_reg        <= high_next;
            co2_reg         <= co2_next;
            temp_reg        <= temp_next;
            hum_reg         <= hum_next;
            err_reg         <= err_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame       = frame_reg;
    assign frame_valid = frame_valid_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FRAME_LAST)
        else $error("byte position ran past the last byte of a frame");

    a_frame_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !last |=> !frame_valid_reg || $stable(frame_reg))
        else $error("frame register changed on a byte that does not end a frame");

    a_crc_reset_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        acc && info.slot == SLOT_CRC |=> crc_reg == CRC_INIT)
        else $error("running CRC not restarted after a CRC byte");

endmodule

`default_nettype wire

FILE: hdl/sfcc_convert.sv
`default_nettype none

module sfcc_convert
    import sfcc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire frame_t   frame,
    input  wire logic     frame_valid,
    output logic          frame_ready,
    sfcc_result_if.source result_ch
);

    logic               valid_reg,  valid_next;
    logic [15:0]        co2_reg;
    logic [15:0]        rawt_reg;
    logic [15:0]        rawh_reg;
    logic signed [14:0] tc_reg;
    logic [13:0]        hc_reg;
    logic [1:0]         err_reg;

    logic               take;
    logic [30:0]        t_prod;
    logic [30:0]        h_prod;
    logic [14:0]        t_quot;
    logic [14:0]        h_quot;
    logic signed [15:0] t_centi;

    assign frame_ready = !valid_reg || result_ch.ready;
    assign take        = frame_valid && frame_ready;

    assign t_prod  = 31'(TEMP_SCALE) * 31'(frame.temp);
    assign h_prod  = 31'(HUM_SCALE) * 31'(frame.hum);
    assign t_quot  = div_full_scale(t_prod);
    assign h_quot  = div_full_scale(h_prod);
    assign t_centi = $signed({1'b0, t_quot}) - $signed(TEMP_OFFSET);

    assign valid_next = take || (valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            co2_reg  <= frame.co2;
            rawt_reg <= frame.temp;
            rawh_reg <= frame.hum;
            tc_reg   <= t_centi[14:0];
            hc_reg   <= h_quot[13:0];
            err_reg  <= frame.err;
        end
    end

    assign result_ch.valid             = valid_reg;
    assign result_ch.co2_ppm           = co2_reg;
    assign result_ch.temperature_code  = rawt_reg;
    assign result_ch.humidity_code     = rawh_reg;
    assign result_ch.temperature_centi = tc_reg;
    assign result_ch.humidity_centi    = hc_reg;
    assign result_ch.crc_ok            = (err_reg == NO_ERROR);
    assign result_ch.bad_word          = err_reg;

    a_no_take_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_ch.ready |-> !frame_ready)
        else $error("frame taken while the result register is still occupied");

    a_humidity_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hc_reg <= HUM_SCALE)
        else $error("humidity conversion out of range");

endmodule

`default_nettype wire

FILE: hdl/sensor_frame_crc_check_convert.sv
`default_nettype none

// Checks and converts the nine-byte measurement frame of a sensor: three
// words of two big-endian data bytes plus a CRC-8 byte (poly 0x31, init 0xFF).
// One byte beat is accepted per clock while ready is high; after the ninth byte
// one result beat carries the three raw words, temperature and humidity in
// hundredths, a pass flag and the index of the first bad word (3 if none).
// The frame register of the byte assembler takes the frame on the edge that
// accepts the ninth byte, and the output register of the converter takes the
// multiplied and scaled values once it is empty or being read. A byte with
// frame_start high drops any partial frame and begins a new one. When the
// result side stalls, bytes still flow until a second frame completes.
module sensor_frame_crc_check_convert
    import sfcc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    sfcc_byte_if.sink     byte_ch,
    sfcc_result_if.source result_ch
);

    frame_t frame;
    logic   frame_valid;
    logic   frame_ready;

    sfcc_assembler u_assembler (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready)
    );

    sfcc_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .result_ch   (result_ch)
    );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcc_pkg::*;

    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned TIMEOUT_NS    = 5_000_000;
    localparam int unsigned DRAIN_LIMIT   = 20_000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned TEMP_SPAN     = 17500;
    localparam int          TEMP_BASE     = -4500;
    localparam int unsigned HUM_SPAN      = 10000;
    localparam int unsigned RAW_FULL      = 65535;
    localparam int unsigned PHASE_BYTES   = 430;

    typedef struct {
        logic [15:0]        co2;
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic               ok;
        logic [1:0]         bad;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sfcc_byte_if   byte_ch ();
    sfcc_result_if result_ch ();

    sensor_frame_crc_check_convert u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    always #10 clk = ~clk;

    // Predicted state of the frame assembler.
    logic [3:0]  frame_pos = 4'd0;
    logic [7:0]  word_crc  = CRC_INIT;
    logic [7:0]  high_hold = 8'd0;
    logic [15:0] co2_hold  = 16'd0;
    logic [15:0] temp_hold = 16'd0;
    logic [15:0] hum_hold  = 16'd0;
    logic [1:0]  first_bad = NO_ERROR;

    frame_result_t expected_frames[$];

    int unsigned src_idle_pct  = 26;
    int unsigned sink_idle_pct = 87;
    int unsigned bytes_sent    = 0;
    int unsigned failures      = 0;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 16'h0000;
        if (pick < 16)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic restart_frame();
        frame_pos = 4'd0;
        word_crc  = CRC_INIT;
        first_bad = NO_ERROR;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic start);
        slot_t         slot;
        logic [1:0]    word;
        frame_result_t r;
        int unsigned   tq;
        int unsigned   hq;
        if (start)
            restart_frame();
        slot = slot_t'(frame_pos % 3);
        word = 2'(frame_pos / 3);
        word_crc = crc8_step(word_crc, b);
        case (slot)
            SLOT_HIGH: high_hold = b;
            SLOT_LOW:
            begin
                case (word)
                    WORD_CO2:  co2_hold  = {high_hold, b};
                    WORD_TEMP: temp_hold = {high_hold, b};
                    default:   hum_hold  = {high_hold, b};
                endcase
            end
            default:
            begin
                // A good word, CRC byte included, leaves a zero remainder.
                if (word_crc != 8'd0 && first_bad == NO_ERROR)
                    first_bad = word;
                word_crc = CRC_INIT;
            end
        endcase
        if (frame_pos == FRAME_LAST)
        begin
            tq = (TEMP_SPAN * int'(temp_hold)) / RAW_FULL;
            hq = (HUM_SPAN * int'(hum_hold)) / RAW_FULL;
            r.co2        = co2_hold;
            r.temp_raw   = temp_hold;
            r.hum_raw    = hum_hold;
            r.temp_centi = 15'(TEMP_BASE + int'(tq));
            r.hum_centi  = 14'(hq);
            r.ok         = (first_bad == NO_ERROR);
            r.bad        = first_bad;
            expected_frames.push_back(r);
            restart_frame();
        end
        else
        begin
            frame_pos = frame_pos + 4'd1;
        end
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv)
            note_failure($sformatf("%s expected %0d, got %0d", name, expv, actv));
    endtask

    // Leaves valid high after the beat is taken; the next call or the caller lowers it.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.rx_byte     <= b;
        byte_ch.frame_start <= start;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1)
            @(posedge clk);
        predict_byte(b, start);
        bytes_sent++;
    endtask

    // Sends the first len bytes of a frame; each set bit of corrupt spoils that word's CRC.
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [2:0] corrupt,
                              input logic start, input int unsigned len);
        logic [15:0] words [3];
        logic [7:0]  frame_bytes [9];
        logic [7:0]  c;
        words = '{w0, w1, w2};
        for (int w = 0; w < 3; w++)
        begin
            c = crc8_step(crc8_step(CRC_INIT, words[w][15:8]), words[w][7:0]);
            if (corrupt[w])
                c = c ^ 8'($urandom_range(255, 1));
            frame_bytes[3*w]     = words[w][15:8];
            frame_bytes[3*w + 1] = words[w][7:0];
            frame_bytes[3*w + 2] = c;
        end
        for (int i = 0; i < len; i++)
            send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
    endtask

    task automatic test_extreme_words();
        send_frame(16'h0000, 16'h0000, 16'h0000, 3'b000, 1'b1, 9);
        // No frame_start here: the count wraps after the previous result.
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b110, 1'b0, 9);
    endtask

    task automatic test_restart_mid_frame();
        send_frame(16'h1234, 16'h5678, 16'h9ABC, 3'b000, 1'b1, 4);
        send_frame(16'h8000, 16'h8000, 16'h7FFF, 3'b001, 1'b1, 9);
        send_frame(16'h0001, 16'hFFFE, 16'h0001, 3'b100, 1'b1, 9);
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        logic [2:0]  corrupt;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            pick    = $urandom_range(99);
            corrupt = ($urandom_range(99) < 70) ? 3'b000 : 3'($urandom);
            if (pick < 75)
                send_frame(rand_word(), rand_word(), rand_word(), corrupt,
                           ($urandom_range(9) != 0), 9);
            else if (pick < 88)
                send_frame(rand_word(), rand_word(), rand_word(), corrupt, 1'b1,
                           $urandom_range(8, 1));
            else
                repeat ($urandom_range(6, 1))
                    send_byte(8'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        while (expected_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure, every accepted beat checked in order.
    initial
    begin
        frame_result_t r;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expected_frames.size() == 0)
                begin
                    note_failure("result beat with no frame outstanding");
                end
                else
                begin
                    r = expected_frames.pop_front();
                    check_field("co2_ppm", r.co2, result_ch.co2_ppm);
                    check_field("temperature_code", r.temp_raw,
                                result_ch.temperature_code);
                    check_field("humidity_code", r.hum_raw, result_ch.humidity_code);
                    check_field("temperature_centi", r.temp_centi,
                                result_ch.temperature_centi);
                    check_field("humidity_centi", r.hum_centi, result_ch.humidity_centi);
                    check_field("crc_ok", r.ok, result_ch.crc_ok);
                    check_field("bad_word", r.bad, result_ch.bad_word);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("sensor_frame_crc_check_convert regression: fail");
        $finish;
    end

    initial
    begin
        byte_ch.valid       <= 1'b0;
        byte_ch.rx_byte     <= 8'd0;
        byte_ch.frame_start <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 26;
        sink_idle_pct = 87;
        test_extreme_words();
        test_restart_mid_frame();
        test_random_traffic(PHASE_BYTES);

        src_idle_pct  = 87;
        sink_idle_pct = 26;
        test_random_traffic(PHASE_BYTES);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(PHASE_BYTES);
        byte_ch.valid <= 1'b0;

        wait_for_results();
        if (expected_frames.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_frames.size()));

        if (failures == 0)
            $display("sensor_frame_crc_check_convert regression: pass");
        else
            $display("sensor_frame_crc_check_convert regression: fail");
        $finish;
    end

endmodule
